// File: sv/filtered_pid_controller_assert.svh
// Assertion shorthands shared by the checker.
`ifndef FILTERED_PID_CONTROLLER_ASSERT_SVH
`define FILTERED_PID_CONTROLLER_ASSERT_SVH

// same-cycle implication, masked while in reset
`define FPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("filtered_pid_controller: same-cycle check failed");

// next-cycle implication, masked while in reset
`define FPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("filtered_pid_controller: next-cycle check failed");

// next-cycle implication, live through reset
`define FPC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("filtered_pid_controller: reset check failed");

`endif

// File: sv/fpc_pkg.sv
package fpc_pkg;

  // controller sequence
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR_FILT,
    ST_SLOPE_FILT,
    ST_DERIV,
    ST_INTEG,
    ST_PROP,
    ST_SUM
  } state_t;

  // register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN_DT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_ALPHA   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_ALPHA   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_MIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_MAX     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIMING_VALID  = 3'd7;

  localparam int ALPHA_W = 17;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  // serial multiplier geometry
  localparam int MUL_A_W   = 34;  // signed multiplicand
  localparam int MUL_B_W   = 32;  // signed multiplier, consumed a digit per cycle
  localparam int DIGIT_W   = 4;
  localparam int MUL_STEPS = MUL_B_W / DIGIT_W;
  localparam int STEP_W    = 3;
  localparam int PROD_W    = 50;  // product >>> 16

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

// File: sv/filtered_pid_controller.sv
// Channel   Signals                                      Direction
// sample    sample_valid, sample_ready, error_sample     in
// result    result_valid, result_ready, drive, saturated out
// config    cfg_we, cfg_index, cfg_data                  in (write only)
//
// One transaction at a time. All products go through one shared multiplier
// that retires a 4-bit digit per cycle; each product is an issue, 8 digit
// steps and a capture. With timing_valid set a transaction takes 5 products
// plus accept and sum; with it clear, 2 products.
// Reset (rst, synchronous) restores register defaults and clears the filter,
// slope and integral state. The result sits in an output register, so the
// next sample is taken while a result stalls; the sum waits only if the
// output register is still full.
module filtered_pid_controller (
  input  logic                            clk,
  input  logic                            rst,
  // sample channel
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  logic signed [31:0]              error_sample,
  // result channel
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic signed [31:0]              drive,
  output logic                            saturated,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [fpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import fpc_pkg::*;

  // saturate a wide sum to 32 bits; top bit flags clipping
  function automatic logic [32:0] sat32(input logic signed [PROD_W-1:0] x);
    logic [32:0] r;
    if (x > 50'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (x < -50'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

  // configuration registers
  logic signed [31:0]  prop_gain;
  logic signed [31:0]  integ_gain_dt;
  logic signed [31:0]  deriv_gain_per_dt;
  logic [ALPHA_W-1:0]  error_alpha;
  logic [ALPHA_W-1:0]  slope_alpha;
  logic signed [31:0]  integ_min;
  logic signed [31:0]  integ_max;
  logic                timing_valid;

  // controller state
  logic signed [31:0]  filtered_error;
  logic signed [31:0]  filtered_slope;
  logic signed [31:0]  integral_term;

  // working registers for one transaction
  logic signed [31:0]  sample_q;
  logic signed [32:0]  step_q;     // fe' - fe
  logic signed [47:0]  d_term;
  logic signed [47:0]  p_term;

  state_t state, state_next;
  logic   issued, issued_next;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  logic accept;
  logic cap_err, cap_slope, cap_deriv, cap_integ, cap_prop, load_out;

  logic [ALPHA_W-1:0] err_alpha_eff;
  logic [ALPHA_W-1:0] slope_alpha_eff;

  // alpha above one acts as one
  assign err_alpha_eff   = error_alpha[ALPHA_W-1] ? ALPHA_ONE : error_alpha;
  assign slope_alpha_eff = slope_alpha[ALPHA_W-1] ? ALPHA_ONE : slope_alpha;

  fpc_serial_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // sequencer: each product state issues once, then waits for done
  always_comb begin
    state_next   = state;
    issued_next  = issued;
    sample_ready = 1'b0;
    accept       = 1'b0;
    cap_err      = 1'b0;
    cap_slope    = 1'b0;
    cap_deriv    = 1'b0;
    cap_integ    = 1'b0;
    cap_prop     = 1'b0;
    load_out     = 1'b0;
    mreq.start   = 1'b0;
    mreq.a       = '0;
    mreq.b       = '0;

    case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          accept     = 1'b1;
          state_next = ST_ERR_FILT;
        end
      end
      ST_ERR_FILT: begin
        mreq.a = MUL_A_W'(sample_q) - MUL_A_W'(filtered_error);
        mreq.b = MUL_B_W'(err_alpha_eff);
        if (mrsp.done) begin
          cap_err    = 1'b1;
          state_next = timing_valid ? ST_SLOPE_FILT : ST_PROP;
        end
      end
      ST_SLOPE_FILT: begin
        mreq.a = MUL_A_W'(step_q) - MUL_A_W'(filtered_slope);
        mreq.b = MUL_B_W'(slope_alpha_eff);
        if (mrsp.done) begin
          cap_slope  = 1'b1;
          state_next = ST_DERIV;
        end
      end
      ST_DERIV: begin
        mreq.a = MUL_A_W'(filtered_slope);
        mreq.b = deriv_gain_per_dt;
        if (mrsp.done) begin
          cap_deriv  = 1'b1;
          state_next = ST_INTEG;
        end
      end
      ST_INTEG: begin
        mreq.a = MUL_A_W'(filtered_error);
        mreq.b = integ_gain_dt;
        if (mrsp.done) begin
          cap_integ  = 1'b1;
          state_next = ST_PROP;
        end
      end
      ST_PROP: begin
        mreq.a = MUL_A_W'(filtered_error);
        mreq.b = prop_gain;
        if (mrsp.done) begin
          cap_prop   = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        // wait only while the previous result is still unclaimed
        if (!result_valid || result_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // one start per product state, cleared on capture
    if (state != ST_IDLE && state != ST_SUM) begin
      if (!issued) begin
        mreq.start  = 1'b1;
        issued_next = 1'b1;
      end else if (mrsp.done) begin
        issued_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain         <= '0;
      integ_gain_dt     <= '0;
      deriv_gain_per_dt <= '0;
      error_alpha       <= ALPHA_ONE;
      slope_alpha       <= ALPHA_ONE;
      integ_min         <= '0;
      integ_max         <= '0;
      timing_valid      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:     prop_gain         <= cfg_data;
        REG_INTEG_GAIN_DT: integ_gain_dt     <= cfg_data;
        REG_DERIV_GAIN:    deriv_gain_per_dt <= cfg_data;
        REG_ERROR_ALPHA:   error_alpha       <= cfg_data[ALPHA_W-1:0];
        REG_SLOPE_ALPHA:   slope_alpha       <= cfg_data[ALPHA_W-1:0];
        REG_INTEG_MIN:     integ_min         <= cfg_data;
        REG_INTEG_MAX:     integ_max         <= cfg_data;
        REG_TIMING_VALID:  timing_valid      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // product post-processing
  logic signed [31:0]      fe_new;
  logic [32:0]             slope_sat;
  logic [32:0]             integ_sat;
  logic signed [31:0]      integ_clamped;
  logic                    signs_differ;
  logic                    clamp_on;
  logic signed [31:0]      i_term;
  logic signed [47:0]      d_use;
  logic [32:0]             sum_sat;

  always_comb begin
    // alpha <= 1 keeps fe' between fe and e, so 32 bits hold it
    fe_new    = filtered_error + mrsp.prod[31:0];
    // full signed product keeps negative filter and integral steps intact
    slope_sat = sat32(PROD_W'(filtered_slope) + mrsp.prod);
    integ_sat = sat32(PROD_W'(integral_term) + mrsp.prod);

    // both bounds zero means no clamp
    clamp_on      = (integ_min != '0) || (integ_max != '0);
    integ_clamped = integ_sat[31:0];
    if (clamp_on) begin
      if ($signed(integ_sat[31:0]) < integ_min) begin
        integ_clamped = integ_min;
      end else if ($signed(integ_sat[31:0]) > integ_max) begin
        integ_clamped = integ_max;
      end
    end

    // integrate only while the integral opposes the error; zero is positive
    signs_differ = integral_term[31] != filtered_error[31];

    i_term  = timing_valid ? integral_term : '0;
    d_use   = timing_valid ? d_term : '0;
    sum_sat = sat32(PROD_W'(p_term) + PROD_W'(i_term) + PROD_W'(d_use));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_error <= '0;
      filtered_slope <= '0;
      integral_term  <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cap_err) begin
        filtered_error <= fe_new;
      end
      if (cap_slope) begin
        filtered_slope <= slope_sat[31:0];
      end
      if (cap_integ && signs_differ) begin
        integral_term <= integ_clamped;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= error_sample;
    end
    if (cap_err) begin
      step_q <= mrsp.prod[32:0];
    end
    if (cap_deriv) begin
      d_term <= mrsp.prod[47:0];
    end
    if (cap_prop) begin
      p_term <= mrsp.prod[47:0];
    end
    if (load_out) begin
      drive     <= sum_sat[31:0];
      saturated <= sum_sat[32];
    end
  end

endmodule

// File: sv/fpc_serial_mul.sv
module fpc_serial_mul (
  input  logic              clk,
  input  logic              rst,
  input  fpc_pkg::mul_req_t req,
  output fpc_pkg::mul_rsp_t rsp
);
  import fpc_pkg::*;

  localparam int PP_W  = MUL_A_W + DIGIT_W + 1;
  localparam int SUM_W = PP_W + 1;
  localparam int ACC_W = SUM_W - DIGIT_W;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MUL_STEPS - 1);

  logic                      busy;
  logic                      done;
  logic [STEP_W-1:0]         cnt;
  logic signed [MUL_A_W-1:0] a_reg;
  logic [MUL_B_W-1:0]        b_reg;
  logic signed [ACC_W-1:0]   acc;

  logic signed [DIGIT_W:0]   digit;
  logic signed [PP_W-1:0]    pp;
  logic signed [SUM_W-1:0]   sum;
  logic signed [ACC_W-1:0]   acc_next;
  logic [MUL_B_W-1:0]        b_next;

  // low digits are unsigned, the top digit carries the sign
  always_comb begin
    if (cnt == LAST_STEP) begin
      digit = {b_reg[DIGIT_W-1], b_reg[DIGIT_W-1:0]};
    end else begin
      digit = {1'b0, b_reg[DIGIT_W-1:0]};
    end
    pp       = PP_W'(a_reg) * PP_W'(digit);
    sum      = SUM_W'(acc) + SUM_W'(pp);
    acc_next = sum[SUM_W-1:DIGIT_W];
    b_next   = {sum[DIGIT_W-1:0], b_reg[MUL_B_W-1:DIGIT_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // low product bits shift into b_reg as multiplier digits retire
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      b_reg <= req.b;
      acc   <= '0;
    end else if (busy) begin
      acc   <= acc_next;
      b_reg <= b_next;
    end
  end

  assign rsp.done = done;
  assign rsp.prod = {acc[PROD_W-16-1:0], b_reg[MUL_B_W-1:16]};

endmodule

// File: sv/fpc_checker.sv
`include "filtered_pid_controller_assert.svh"

module fpc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic signed [31:0]            drive,
  input logic                          saturated
);

  // reset empties the output register
  `FPC_ASSERT_NEXT_ALWAYS(a_reset_clears_result, clk, rst, !result_valid)

  // one transaction in flight: intake closes right after an accept
  `FPC_ASSERT_NEXT(a_intake_closes, clk, rst, sample_valid && sample_ready, !sample_ready)

  // a stalled result stays put
  `FPC_ASSERT_NEXT(a_result_held, clk, rst, result_valid && !result_ready, result_valid && $stable(drive) && $stable(saturated))

  // the clip flag only comes with a rail value
  `FPC_ASSERT_IMPL(a_sat_at_rail, clk, rst, result_valid && saturated, drive == 32'sh7fff_ffff || drive == 32'sh8000_0000)

endmodule

bind filtered_pid_controller fpc_checker u_fpc_checker (.*);

// File: tb/sv/fpc_drive_checker.sv
`timescale 1ns / 1ps

// Watches the sample, result and config channels of filtered_pid_controller.
// Each accepted sample is run through a Q16.16 model of the controller, and
// each accepted result is compared with the oldest drive word still waiting.
module fpc_drive_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  input  logic                        sample_ready,
  input  logic signed [31:0]          error_sample,
  input  logic                        result_valid,
  input  logic                        result_ready,
  input  logic signed [31:0]          drive,
  input  logic                        saturated,
  input  logic                        cfg_we,
  input  logic [fpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  output int                          mismatches,
  output int                          outstanding,
  output int                          checked
);
  import fpc_pkg::*;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               saturated;
  } drive_word_t;

  localparam longint UNITY  = longint'(ALPHA_ONE);
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  // register copies
  longint kp, ki_dt, kd_dt, err_alpha, slp_alpha, integ_lo, integ_hi;
  logic   timing_on;
  // controller state
  longint filt_err, filt_slope, integ_acc;

  drive_word_t pending_drives[$];

  // arithmetic shift of a signed value: floor division by 2^16
  function automatic longint floor16(input longint x);
    return x >>> 16;
  endfunction

  function automatic longint smooth(input longint prev, input longint target,
                                    input longint alpha);
    longint a;
    a = (alpha > UNITY) ? UNITY : alpha;
    return prev + floor16(a * (target - prev));
  endfunction

  function automatic longint clip32(input longint x, output logic hit);
    hit = 1'b1;
    if (x > S32_HI) return S32_HI;
    if (x < S32_LO) return S32_LO;
    hit = 1'b0;
    return x;
  endfunction

  task automatic predict_drive(input logic signed [31:0] e);
    longint      fe, p_term, i_term, d_term, acc, total;
    logic        hit;
    drive_word_t w;
    fe     = smooth(filt_err, longint'(e), err_alpha);
    i_term = 0;
    d_term = 0;
    if (timing_on) begin
      filt_slope = clip32(smooth(filt_slope, fe - filt_err, slp_alpha), hit);
      d_term     = floor16(filt_slope * kd_dt);
      // anti-windup: integrate only against the current sign (zero is positive)
      if ((integ_acc < 0) != (fe < 0)) begin
        acc = clip32(integ_acc + floor16(fe * ki_dt), hit);
        if (!(integ_lo == 0 && integ_hi == 0)) begin
          if (acc < integ_lo) acc = integ_lo;
          else if (acc > integ_hi) acc = integ_hi;
        end
        integ_acc = acc;
      end
      i_term = integ_acc;
    end
    p_term   = floor16(fe * kp);
    filt_err = fe;
    total    = clip32(p_term + i_term + d_term, hit);
    w.drive     = total[31:0];
    w.saturated = hit;
    pending_drives.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    mismatches++;
    $display("%0t ns drive check: %s got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    drive_word_t want;
    if (rst) begin
      kp         = 0;
      ki_dt      = 0;
      kd_dt      = 0;
      err_alpha  = UNITY;
      slp_alpha  = UNITY;
      integ_lo   = 0;
      integ_hi   = 0;
      timing_on  = 1'b0;
      filt_err   = 0;
      filt_slope = 0;
      integ_acc  = 0;
      pending_drives.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:     kp        = longint'($signed(cfg_data));
          REG_INTEG_GAIN_DT: ki_dt     = longint'($signed(cfg_data));
          REG_DERIV_GAIN:    kd_dt     = longint'($signed(cfg_data));
          REG_ERROR_ALPHA:   err_alpha = longint'(cfg_data[ALPHA_W-1:0]);
          REG_SLOPE_ALPHA:   slp_alpha = longint'(cfg_data[ALPHA_W-1:0]);
          REG_INTEG_MIN:     integ_lo  = longint'($signed(cfg_data));
          REG_INTEG_MAX:     integ_hi  = longint'($signed(cfg_data));
          REG_TIMING_VALID:  timing_on = cfg_data[0];
          default: ;
        endcase
      end
      if (sample_valid && sample_ready)
        predict_drive(error_sample);
      if (result_valid && result_ready) begin
        if (pending_drives.size() == 0) begin
          report_mismatch("unexpected transaction, drive", longint'(drive), 0);
        end else begin
          want = pending_drives.pop_front();
          checked++;
          if (drive !== want.drive)
            report_mismatch("drive", longint'(drive), longint'(want.drive));
          if (saturated !== want.saturated)
            report_mismatch("saturated", longint'(saturated), longint'(want.saturated));
        end
      end
    end
    outstanding <= pending_drives.size();
  end

endmodule

// File: tb/sv/filtered_pid_controller_tb.sv
`timescale 1ns / 1ps

module filtered_pid_controller_tb;
  import fpc_pkg::*;

  localparam int RANDOM_ITEMS   = 1550;
  localparam int RX_HOLD_CYCLES = 400;   // long enough to back the block up
  localparam int SETTLE_CYCLES  = 60;    // longer than one full transaction with timing_valid set

  logic               clk = 1'b0;
  logic               rst;
  logic               sample_valid;
  logic               sample_ready;
  logic signed [31:0] error_sample;
  logic               result_valid;
  logic               result_ready;
  logic signed [31:0] drive;
  logic               saturated;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]        cfg_data;

  int   mismatches;
  int   outstanding;
  int   checked;
  int   samples_sent;
  int   settings_used;
  int   hold_requests = 0;  // bumped by stimulus, served by the result sink
  logic no_idle;            // burst mode: neither side inserts gaps

  always #10 clk = ~clk;

  // hard stop well past the slowest legal run (~6.4 ms)
  initial begin
    #(40_000_000);
    $display("TB_ERROR");
    $finish;
  end

  filtered_pid_controller i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .error_sample (error_sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .drive        (drive),
    .saturated    (saturated),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  fpc_drive_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .error_sample (error_sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .drive        (drive),
    .saturated    (saturated),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .checked      (checked)
  );

  // Idle length: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // Error samples: mostly small so the integral actually winds and unwinds,
  // with mid-range, full 32-bit and rail values mixed in.
  function automatic logic [31:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    if (r < 75) return 32'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
    if (r < 92) return $urandom;
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom;
    if (r < 60) return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    if (r < 70) return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
    if (r < 80) return 32'h0000_0000;
    if (r < 90) return 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  // Filter coefficient: zero, unity, above unity (acts as unity) or fractional.
  function automatic logic [31:0] rand_alpha();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0;
    if (r < 25) return 32'(ALPHA_ONE);
    if (r < 33) return $urandom_range(65537, 131071);
    if (r < 36) return $urandom;
    return $urandom_range(1, 65535);
  endfunction

  // One register write per clock; caller drops cfg_we afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Full register set; only called while nothing is in flight.
  task automatic load_settings(input logic [31:0] p_gain, input logic [31:0] i_gain,
                               input logic [31:0] d_gain, input logic [31:0] e_alpha,
                               input logic [31:0] s_alpha, input logic [31:0] lo,
                               input logic [31:0] hi, input logic [31:0] timing);
    write_reg(REG_PROP_GAIN, p_gain);
    write_reg(REG_INTEG_GAIN_DT, i_gain);
    write_reg(REG_DERIV_GAIN, d_gain);
    write_reg(REG_ERROR_ALPHA, e_alpha);
    write_reg(REG_SLOPE_ALPHA, s_alpha);
    write_reg(REG_INTEG_MIN, lo);
    write_reg(REG_INTEG_MAX, hi);
    write_reg(REG_TIMING_VALID, timing);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Offer one sample after a random gap; returns on the accepting edge.
  // Valid is only lowered when a gap follows, so back-to-back transactions
  // keep it high without a glitch.
  task automatic send_sample(input logic [31:0] e);
    int n;
    n = gap_len();
    if (n > 0) begin
      sample_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    sample_valid <= 1'b1;
    error_sample <= e;
    do @(posedge clk); while (!sample_ready);
    samples_sent++;
  endtask

  // Sender goes quiet until every predicted drive word has come back.
  task automatic drain_results();
    sample_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Result sink: random stalls, plus a long hold-off whenever one is requested.
  initial begin : result_sink
    int served;
    int n;
    served = 0;
    result_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_requests != served) begin
        served++;
        result_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          result_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      result_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [31:0] rails[5]    = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1};
    logic [31:0] swings[6]   = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0};
    logic [31:0] crossed[5]  = '{32'h0003_0000, 32'hFFFD_0000, 32'hFFFF_FFFF,
                                 32'h0005_0000, 32'hFFF0_0000};
    logic [31:0] frozen[3]   = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345};
    logic [31:0] clamping[4] = '{32'h0010_0000, 32'hFFF0_0000, 32'h0010_0000, 32'hFFF0_0000};
    logic [31:0] lo, hi;
    int random_sent;
    int phase;
    int n;
    int r;

    rst          <= 1'b1;
    sample_valid <= 1'b0;
    error_sample <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    no_idle      <= 1'b0;
    samples_sent  = 0;
    settings_used = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // timing off, huge P gain: drive clips at both rails, I and D stay out
    load_settings(32'h7FFF_FFFF, 32'h0, 32'h0, 32'(ALPHA_ONE), 32'(ALPHA_ONE),
                  32'h0, 32'h0, 32'h0);
    foreach (rails[k]) send_sample(rails[k]);
    drain_results();

    // rail-to-rail swings with max I/D gains: slope and integral both
    // saturate, clamp off (both bounds zero), alphas written above unity
    load_settings(32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_FFFF,
                  32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1);
    foreach (swings[k]) send_sample(swings[k]);
    drain_results();

    // crossed bounds (min > max), negative gains, partial filtering,
    // negative products exercise floor rounding
    load_settings(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_8000, 32'h0000_4000,
                  32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000, 32'h1);
    foreach (crossed[k]) send_sample(crossed[k]);
    drain_results();

    // zero alphas: filtered error and slope hold whatever they had
    load_settings(32'h0002_0000, 32'h0000_8000, 32'h0001_0000, 32'h0, 32'h0,
                  32'hFFFB_0000, 32'h0005_0000, 32'h1);
    foreach (frozen[k]) send_sample(frozen[k]);
    drain_results();

    // ordered clamp that actually bites on each sign change
    load_settings(32'h0001_0000, 32'h0001_0000, 32'h0, 32'(ALPHA_ONE), 32'(ALPHA_ONE),
                  32'hFFFE_0000, 32'h0002_0000, 32'h1);
    foreach (clamping[k]) send_sample(clamping[k]);
    drain_results();

    // --- random phases: new settings, a burst of samples, full drain ---
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 2) begin
        lo = 32'h0;                       // clamp off
        hi = 32'h0;
      end else if (r < 7) begin
        lo = 32'(-int'($urandom_range(0, 1 << 22)));
        hi = $urandom_range(0, 1 << 22);
      end else if (r < 8) begin
        lo = $urandom_range(1, 1 << 20);  // crossed
        hi = 32'(-int'($urandom_range(0, 1 << 20)));
      end else begin
        lo = $urandom;
        hi = $urandom;
      end
      load_settings(rand_gain(), rand_gain(), rand_gain(), rand_alpha(), rand_alpha(),
                    lo, hi, 32'($urandom_range(0, 4) != 0));
      no_idle <= ($urandom_range(0, 4) == 0);
      n = $urandom_range(20, 90);
      for (int k = 0; k < n; k++) begin
        // one long receiver hold-off while samples keep coming: fills the
        // output register and stalls the next sum, so sample_ready stays low
        if ((phase == 2 && k == 3) || $urandom_range(0, 999) == 0)
          hold_requests <= hold_requests + 1;
        send_sample(rand_sample());
        random_sent++;
      end
      drain_results();
      phase++;
    end

    no_idle <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d samples under %0d register settings; %0d drive words checked.",
             samples_sent, settings_used, checked);
    $display("Included rail gains, clamp off and crossed bounds, zero and over-unity alphas, "
             , "timing off, and a long result hold-off.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filtered_pid_controller.f
+incdir+sv
sv/fpc_pkg.sv
sv/fpc_serial_mul.sv
sv/filtered_pid_controller.sv
sv/fpc_checker.sv
tb/sv/fpc_drive_checker.sv
tb/sv/filtered_pid_controller_tb.sv
